// ===== rtl/phl_pkg.sv =====
// shared constants, types and the modulo step function of the perfect hash lookup
// no dependencies
package phl_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int OFFSET_DEPTH = 256;
    localparam int OFFSET_WIDTH = 11;

    localparam int TIDX_W = $clog2(TABLE_DEPTH);
    localparam int OIDX_W = $clog2(OFFSET_DEPTH);
    localparam int SIZE_W = TIDX_W + 1;
    localparam int REM_W  = TIDX_W;
    localparam int KEY_W  = 64;

    localparam int DIG_BITS = 8;
    localparam int DIG_STG  = KEY_W / DIG_BITS;
    localparam int PW       = 2 * REM_W + 1;
    localparam int P_STG    = 3;
    localparam int P_BITS   = (PW + P_STG - 1) / P_STG;
    localparam int P_PAD    = P_STG * P_BITS;

    typedef enum logic [1:0] {
        ACT_WR_OFFSET = 2'd0,
        ACT_WR_KEY    = 2'd1,
        ACT_LOOKUP    = 2'd2,
        ACT_NONE      = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_HIT      = 3'd1,
        ST_MISS     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_RANGE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        REG_TABLE_SIZE  = 2'd0,
        REG_TABLE_WRAP  = 2'd1,
        REG_OFFSET_SIZE = 2'd2,
        REG_OFFSET_WRAP = 2'd3
    } t_reg;

    typedef struct packed {
        t_action                 action;
        logic [TIDX_W-1:0]       idx;
        logic [KEY_W-1:0]        khi;
        logic [KEY_W-1:0]        klo;
        logic [OFFSET_WIDTH-1:0] oval;
        logic                    wr_ok;
        logic                    ovf;
    } t_item;

    // one restoring step: shift in a bit, subtract the modulus once if it fits
    function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] r,
                                                  input logic b,
                                                  input logic [SIZE_W-1:0] n);
        logic [REM_W:0] t;
        logic [REM_W:0] d;
        t = {r, b};
        d = t - n;
        if (t >= n) begin
            return d[REM_W-1:0];
        end
        return t[REM_W-1:0];
    endfunction

endpackage

// ===== rtl/phl_if.sv =====
// handshake channel interfaces of the perfect hash lookup
// depends on phl_pkg
interface phl_in_if;
    import phl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [1:0]              action;
    logic [TIDX_W-1:0]       slot_index;
    logic [KEY_W-1:0]        key_high;
    logic [KEY_W-1:0]        key_low;
    logic [OFFSET_WIDTH-1:0] offset_value;
    modport source (output valid, action, slot_index, key_high, key_low, offset_value,
                    input ready);
    modport sink   (input valid, action, slot_index, key_high, key_low, offset_value,
                    output ready);
endinterface

interface phl_out_if;
    import phl_pkg::*;
    logic              valid;
    logic              ready;
    logic [2:0]        status;
    logic [TIDX_W-1:0] slot;
    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

interface phl_cfg_if;
    import phl_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [SIZE_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/phl_reduce.sv =====
// pipelined 128-bit modulo: (hi*2^64 + lo) mod n using wrap = 2^64 mod n
// depends on phl_pkg; digit stages, a fold register and final reduction stages, advancing on i_en
module phl_reduce
    import phl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_item             i_item,
    input  logic [KEY_W-1:0]  i_hi,
    input  logic [KEY_W-1:0]  i_lo,
    input  logic [SIZE_W-1:0] i_n,
    input  logic [REM_W-1:0]  i_wrap,
    output logic              o_vld,
    output t_item             o_item,
    output logic [REM_W-1:0]  o_rem
);

    logic             r_dvld [DIG_STG];
    t_item            r_dit  [DIG_STG];
    logic [REM_W-1:0] r_hrem [DIG_STG];
    logic [REM_W-1:0] r_lrem [DIG_STG];
    logic [KEY_W-1:0] r_hop  [DIG_STG];
    logic [KEY_W-1:0] r_lop  [DIG_STG];

    // digit stages, both halves in parallel
    for (genvar s = 0; s < DIG_STG; s++) begin : g_dig
        logic             s_vld;
        t_item            s_it;
        logic [REM_W-1:0] s_hr, s_lr, n_hr, n_lr;
        logic [KEY_W-1:0] s_ho, s_lo;
        if (s == 0) begin : g_first
            assign s_vld = i_vld;
            assign s_it  = i_item;
            assign s_hr  = '0;
            assign s_lr  = '0;
            assign s_ho  = i_hi;
            assign s_lo  = i_lo;
        end else begin : g_next
            assign s_vld = r_dvld[s-1];
            assign s_it  = r_dit[s-1];
            assign s_hr  = r_hrem[s-1];
            assign s_lr  = r_lrem[s-1];
            assign s_ho  = r_hop[s-1];
            assign s_lo  = r_lop[s-1];
        end
        always_comb begin
            n_hr = s_hr;
            n_lr = s_lr;
            for (int b = 0; b < DIG_BITS; b++) begin
                n_hr = mod_step(n_hr, s_ho[KEY_W-1-b], i_n);
                n_lr = mod_step(n_lr, s_lo[KEY_W-1-b], i_n);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[s] <= 1'b0;
            end else if (i_en) begin
                r_dvld[s] <= s_vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dit[s]  <= s_it;
                r_hrem[s] <= n_hr;
                r_lrem[s] <= n_lr;
                r_hop[s]  <= s_ho << DIG_BITS;
                r_lop[s]  <= s_lo << DIG_BITS;
            end
        end
    end

    // fold: high remainder times wrap plus low remainder
    logic          r_mvld;
    t_item         r_mit;
    logic [PW-1:0] r_p;
    logic [PW-1:0] n_p;

    assign n_p = PW'(r_hrem[DIG_STG-1]) * PW'(i_wrap) + PW'(r_lrem[DIG_STG-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (i_en) begin
            r_mvld <= r_dvld[DIG_STG-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mit <= r_dit[DIG_STG-1];
            r_p   <= n_p;
        end
    end

    // final reduction of the folded value
    logic             r_pvld [P_STG];
    t_item            r_pit  [P_STG];
    logic [REM_W-1:0] r_prem [P_STG];
    logic [P_PAD-1:0] r_pop  [P_STG];

    for (genvar s = 0; s < P_STG; s++) begin : g_fold
        logic             s_vld;
        t_item            s_it;
        logic [REM_W-1:0] s_r, n_r;
        logic [P_PAD-1:0] s_op;
        if (s == 0) begin : g_first
            assign s_vld = r_mvld;
            assign s_it  = r_mit;
            assign s_r   = '0;
            assign s_op  = P_PAD'(r_p);
        end else begin : g_next
            assign s_vld = r_pvld[s-1];
            assign s_it  = r_pit[s-1];
            assign s_r   = r_prem[s-1];
            assign s_op  = r_pop[s-1];
        end
        always_comb begin
            n_r = s_r;
            for (int b = 0; b < P_BITS; b++) begin
                n_r = mod_step(n_r, s_op[P_PAD-1-b], i_n);
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_pvld[s] <= 1'b0;
            end else if (i_en) begin
                r_pvld[s] <= s_vld;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pit[s]  <= s_it;
                r_prem[s] <= n_r;
                r_pop[s]  <= s_op << P_BITS;
            end
        end
    end

    assign o_vld  = r_pvld[P_STG-1];
    assign o_item = r_pit[P_STG-1];
    assign o_rem  = r_prem[P_STG-1];

endmodule

// ===== rtl/perfect_hash_lookup_128_core.sv =====
// top level of the two-level perfect hash lookup for 128-bit keys
// depends on phl_pkg, phl_if and phl_reduce
//
// One word in, one word out, in order. The pipeline takes a new word every cycle
// while the output is not stalled and the clearing pass is over. A word passes
// through two bit-serial modulo pipelines of eight key bits per digit stage,
// the displacement memory read, a two-stage 128-bit add, the key memory
// read and the compare/output register. A stalled output freezes the whole
// pipeline. After reset the key memory is cleared one slot per cycle, so input
// ready stays low until every slot is cleared; configuration writes are taken
// at any time but must only be issued while no word is in flight.
module perfect_hash_lookup_128_core
    import phl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    phl_in_if.sink    i_in,
    phl_out_if.source o_out,
    phl_cfg_if.sink   i_cfg
);

    // configuration registers
    logic [SIZE_W-1:0] r_table_size;
    logic [REM_W-1:0]  r_table_wrap;
    logic [OIDX_W:0]   r_offset_size;
    logic [OIDX_W-1:0] r_offset_wrap;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size  <= SIZE_W'(TABLE_DEPTH);
            r_table_wrap  <= '0;
            r_offset_size <= (OIDX_W+1)'(OFFSET_DEPTH);
            r_offset_wrap <= '0;
        end else if (i_cfg.valid) begin
            unique case (t_reg'(i_cfg.index))
                REG_TABLE_SIZE:  r_table_size  <= i_cfg.data;
                REG_TABLE_WRAP:  r_table_wrap  <= i_cfg.data[REM_W-1:0];
                REG_OFFSET_SIZE: r_offset_size <= i_cfg.data[OIDX_W:0];
                REG_OFFSET_WRAP: r_offset_wrap <= i_cfg.data[OIDX_W-1:0];
                default: ;
            endcase
        end
    end

    // active sizes: zero acts as one, anything above the depth acts as the depth
    logic [SIZE_W-1:0] tsz, osz;

    always_comb begin
        if (r_table_size == '0) begin
            tsz = SIZE_W'(1);
        end else if (r_table_size > SIZE_W'(TABLE_DEPTH)) begin
            tsz = SIZE_W'(TABLE_DEPTH);
        end else begin
            tsz = r_table_size;
        end
        if (r_offset_size == '0) begin
            osz = SIZE_W'(1);
        end else if (r_offset_size > (OIDX_W+1)'(OFFSET_DEPTH)) begin
            osz = SIZE_W'(OFFSET_DEPTH);
        end else begin
            osz = SIZE_W'(r_offset_size);
        end
    end

    // key memory clearing pass after reset
    logic              r_clr_busy;
    logic [TIDX_W-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == TIDX_W'(TABLE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // global advance: the output register is free or being emptied
    logic r_o_vld;
    logic en;

    assign en         = !r_o_vld || o_out.ready;
    assign i_in.ready = en && !r_clr_busy;

    // entry: build the item and judge write ranges up front
    t_item in_item;
    logic  in_vld;

    assign in_vld = i_in.valid && i_in.ready;

    always_comb begin
        in_item.action = t_action'(i_in.action);
        in_item.idx    = i_in.slot_index;
        in_item.khi    = i_in.key_high;
        in_item.klo    = i_in.key_low;
        in_item.oval   = i_in.offset_value;
        in_item.ovf    = 1'b0;
        unique case (t_action'(i_in.action))
            ACT_WR_OFFSET: in_item.wr_ok = SIZE_W'(i_in.slot_index) < osz;
            ACT_WR_KEY:    in_item.wr_ok = SIZE_W'(i_in.slot_index) < tsz;
            default:       in_item.wr_ok = 1'b0;
        endcase
    end

    // first reduction: key mod offset size picks the displacement
    logic             a_vld;
    t_item            a_it;
    logic [REM_W-1:0] a_rem;

    phl_reduce u_red_offset (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (in_vld),
        .i_item  (in_item),
        .i_hi    (in_item.khi),
        .i_lo    (in_item.klo),
        .i_n     (osz),
        .i_wrap  (REM_W'(r_offset_wrap)),
        .o_vld   (a_vld),
        .o_item  (a_it),
        .o_rem   (a_rem)
    );

    // displacement memory: writes and reads happen at this one stage, so order holds
    logic [OFFSET_WIDTH-1:0] r_off_mem [OFFSET_DEPTH];
    logic [OFFSET_WIDTH-1:0] r_disp;
    logic                    r_m_vld;
    t_item                   r_m_it;

    always_ff @(posedge i_clk) begin
        if (en && a_vld && a_it.action == ACT_WR_OFFSET && a_it.wr_ok) begin
            r_off_mem[a_it.idx[OIDX_W-1:0]] <= a_it.oval;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_disp <= r_off_mem[a_rem[OIDX_W-1:0]];
            r_m_it <= a_it;
        end
    end

    // add displacement, low half then high half
    logic [KEY_W-1:0] r_l_slo;
    logic             r_l_c;
    logic             r_l_vld;
    t_item            r_l_it;
    logic [KEY_W:0]   n_lsum;

    assign n_lsum = (KEY_W+1)'(r_m_it.klo) + (KEY_W+1)'(r_disp);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_l_slo <= n_lsum[KEY_W-1:0];
            r_l_c   <= n_lsum[KEY_W];
            r_l_it  <= r_m_it;
        end
    end

    logic [KEY_W-1:0] r_h_shi, r_h_slo;
    logic             r_h_vld;
    t_item            r_h_it;
    t_item            n_h_it;
    logic [KEY_W:0]   n_hsum;

    assign n_hsum = (KEY_W+1)'(r_l_it.khi) + (KEY_W+1)'(r_l_c);

    // carry out of the high half marks overflow
    always_comb begin
        n_h_it     = r_l_it;
        n_h_it.ovf = n_hsum[KEY_W];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_shi <= n_hsum[KEY_W-1:0];
            r_h_slo <= r_l_slo;
            r_h_it  <= n_h_it;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
            r_l_vld <= 1'b0;
            r_h_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= a_vld;
            r_l_vld <= r_m_vld;
            r_h_vld <= r_l_vld;
        end
    end

    // second reduction: sum mod table size gives the slot
    logic             b_vld;
    t_item            b_it;
    logic [REM_W-1:0] b_rem;

    phl_reduce u_red_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_h_vld),
        .i_item  (r_h_it),
        .i_hi    (r_h_shi),
        .i_lo    (r_h_slo),
        .i_n     (tsz),
        .i_wrap  (r_table_wrap),
        .o_vld   (b_vld),
        .o_item  (b_it),
        .o_rem   (b_rem)
    );

    // key memory, one 128-bit word per slot; zero marks an empty slot
    logic [2*KEY_W-1:0] r_key_mem [TABLE_DEPTH];
    logic [2*KEY_W-1:0] r_kd;
    logic               r_k_vld;
    t_item              r_k_it;
    logic [TIDX_W-1:0]  r_k_slot;

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_key_mem[r_clr_cnt] <= '0;
        end else if (en && b_vld && b_it.action == ACT_WR_KEY && b_it.wr_ok) begin
            r_key_mem[b_it.idx] <= {b_it.khi, b_it.klo};
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kd     <= r_key_mem[b_rem];
            r_k_it   <= b_it;
            r_k_slot <= b_rem;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld <= 1'b0;
        end else if (en) begin
            r_k_vld <= b_vld;
        end
    end

    // compare and result register
    t_status           n_status;
    logic [TIDX_W-1:0] n_slot;
    t_status           r_o_status;
    logic [TIDX_W-1:0] r_o_slot;
    logic              hit;

    assign hit = (r_kd != '0) && (r_kd == {r_k_it.khi, r_k_it.klo});

    always_comb begin
        unique case (r_k_it.action)
            ACT_WR_OFFSET, ACT_WR_KEY: begin
                n_status = r_k_it.wr_ok ? ST_DONE : ST_RANGE;
                n_slot   = r_k_it.idx;
            end
            ACT_LOOKUP: begin
                if (r_k_it.ovf) begin
                    n_status = ST_OVERFLOW;
                    n_slot   = '0;
                end else begin
                    n_status = hit ? ST_HIT : ST_MISS;
                    n_slot   = r_k_slot;
                end
            end
            default: begin
                n_status = ST_RANGE;
                n_slot   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_k_vld;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_status <= n_status;
            r_o_slot   <= n_slot;
        end
    end

    assign o_out.valid  = r_o_vld;
    assign o_out.status = r_o_status;
    assign o_out.slot   = r_o_slot;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// self-checking testbench of perfect_hash_lookup_128_core with a scoreboard class
// depends on phl_pkg, phl_if and the core rtl

module testbench;
    import phl_pkg::*;

    typedef struct {
        t_action     action;
        bit [9:0]    idx;
        bit [63:0]   khi;
        bit [63:0]   klo;
        bit [10:0]   oval;
    } hash_word_t;

    typedef struct {
        t_status     status;
        bit [9:0]    slot;
    } answer_t;

    // keeps its own copy of both stores and the registers, predicts one answer per word
    class hash_scoreboard;
        bit [10:0]   offs [OFFSET_DEPTH];
        bit [63:0]   khi [TABLE_DEPTH];
        bit [63:0]   klo [TABLE_DEPTH];
        bit [10:0]   tsize;
        bit [9:0]    twrap;
        bit [8:0]    osize;
        bit [7:0]    owrap;
        answer_t     answers [$];
        int          errors;
        int          checked;
        int          hits;
        int          overflows;

        function new();
            tsize = 11'd1024;
            osize = 9'd256;
        endfunction

        function bit [63:0] active(bit [63:0] n, bit [63:0] depth);
            if (n == 64'd0) return 64'd1;
            if (n > depth) return depth;
            return n;
        endfunction

        function bit [63:0] fold(bit [63:0] hi, bit [63:0] lo, bit [63:0] n, bit [63:0] w);
            bit [63:0] p;
            p = (hi % n) * w;
            p += lo % n;
            return p % n;
        endfunction

        // final slot of a key, or overflow of key plus displacement
        function void locate(bit [63:0] hi, bit [63:0] lo, output bit ovf,
                             output bit [9:0] s);
            bit [63:0]  oi;
            bit [128:0] sum;
            oi  = fold(hi, lo, active(64'(osize), 64'(OFFSET_DEPTH)), 64'(owrap));
            sum = {1'b0, hi, lo} + 129'(offs[oi]);
            ovf = sum[128];
            s   = ovf ? 10'd0
                      : 10'(fold(sum[127:64], sum[63:0], active(64'(tsize), 64'(TABLE_DEPTH)),
                                 64'(twrap)));
        endfunction

        function void set_reg(t_reg r, bit [10:0] v);
            case (r)
                REG_TABLE_SIZE:  tsize = v;
                REG_TABLE_WRAP:  twrap = v[9:0];
                REG_OFFSET_SIZE: osize = v[8:0];
                default:         owrap = v[7:0];
            endcase
        endfunction

        function void note(hash_word_t w);
            answer_t a;
            bit      ovf;
            bit [9:0] s;
            a.slot = w.idx;
            a.status = ST_DONE;
            case (w.action)
                ACT_WR_OFFSET: begin
                    if (64'(w.idx) < active(64'(osize), 64'(OFFSET_DEPTH)))
                        offs[w.idx] = w.oval;
                    else a.status = ST_RANGE;
                end
                ACT_WR_KEY: begin
                    if (64'(w.idx) < active(64'(tsize), 64'(TABLE_DEPTH))) begin
                        khi[w.idx] = w.khi;
                        klo[w.idx] = w.klo;
                    end else a.status = ST_RANGE;
                end
                ACT_LOOKUP: begin
                    locate(w.khi, w.klo, ovf, s);
                    a.slot = s;
                    if (ovf) begin
                        a.status = ST_OVERFLOW;
                        overflows++;
                    end else if ((khi[s] | klo[s]) != 64'd0 && khi[s] == w.khi
                                 && klo[s] == w.klo) begin
                        a.status = ST_HIT;
                        hits++;
                    end else a.status = ST_MISS;
                end
                default: begin
                    a.status = ST_RANGE;
                    a.slot = '0;
                end
            endcase
            answers.push_back(a);
        endfunction

        function void check(bit [2:0] st, bit [9:0] sl);
            answer_t a;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result status %0d slot %0d", $time, st, sl);
                errors++;
                return;
            end
            a = answers.pop_front();
            checked++;
            if (st != a.status) begin
                $display("%0t: status expected %0d actual %0d", $time, a.status, st);
                errors++;
            end
            if (sl != a.slot) begin
                $display("%0t: slot expected %0d actual %0d", $time, a.slot, sl);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT   = 400000;
    localparam int DRAIN   = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   stall_left = 0;
    bit   calm = 1'b0;
    hash_scoreboard sb = new();

    phl_in_if  in_ch ();
    phl_out_if out_ch ();
    phl_cfg_if cfg_ch ();

    perfect_hash_lookup_128_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // result side: check each taken word, stall ready in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.status, out_ch.slot);
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = int'($urandom_range(1, 8)) - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // drive one word and wait for it to be taken; valid stays high afterwards unless a random sender gap drops it
    task automatic send_word(t_action act, bit [9:0] idx, bit [63:0] hi, bit [63:0] lo,
                             bit [10:0] ov);
        hash_word_t w;
        w = '{act, idx, hi, lo, ov};
        in_ch.valid        <= 1'b1;
        in_ch.action       <= act;
        in_ch.slot_index   <= idx;
        in_ch.key_high     <= hi;
        in_ch.key_low      <= lo;
        in_ch.offset_value <= ov;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sb.note(w);
        // random sender gap
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // valid stays high so writes can follow each other; the caller drops it
    task automatic write_reg(t_reg r, bit [10:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= r;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        sb.set_reg(r, v);
    endtask

    function automatic bit [63:0] wrap_of(bit [63:0] n);
        bit [64:0] t;
        t = 65'h1 << 64;
        return 64'(t % 65'(n));
    endfunction

    // new settings only once the pipeline is empty
    task automatic reconfigure(bit [10:0] tsz, bit [10:0] osz, bit good_wrap);
        in_ch.valid <= 1'b0;
        while (sb.answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        write_reg(REG_TABLE_SIZE, tsz);
        write_reg(REG_OFFSET_SIZE, osz);
        write_reg(REG_TABLE_WRAP, good_wrap
                  ? 11'(wrap_of(sb.active(64'(tsz), 64'(TABLE_DEPTH))))
                  : 11'($urandom_range(0, 2047)));
        write_reg(REG_OFFSET_WRAP, good_wrap
                  ? 11'(wrap_of(sb.active(64'(osz[8:0]), 64'(OFFSET_DEPTH))))
                  : 11'($urandom_range(0, 2047)));
        cfg_ch.valid <= 1'b0;
    endtask

    // store a key where the lookup will land unless it overflows, then look it up
    task automatic store_and_find(bit [63:0] hi, bit [63:0] lo);
        bit       ovf;
        bit [9:0] s;
        sb.locate(hi, lo, ovf, s);
        if (!ovf) send_word(ACT_WR_KEY, s, hi, lo, 11'($urandom));
        send_word(ACT_LOOKUP, 10'($urandom), hi, lo, 11'($urandom));
    endtask

    function automatic bit [63:0] rand_key();
        case ($urandom_range(0, 5))
            0:       return '1;
            1:       return 64'($urandom_range(0, 3));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic random_word();
        bit [9:0] s;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4, 5, 6: store_and_find(rand_key(), rand_key());
            7, 8: begin
                // look up a key already in the store
                s = 10'($urandom);
                send_word(ACT_LOOKUP, 10'($urandom), sb.khi[s], sb.klo[s], 11'($urandom));
            end
            9:      send_word(ACT_LOOKUP, 10'($urandom), rand_key(), rand_key(), 11'($urandom));
            10, 11: send_word(ACT_WR_OFFSET, 10'($urandom_range(0, 300)), '0, '0,
                              11'($urandom));
            12:     send_word(ACT_WR_OFFSET, 10'($urandom), '0, '0, 11'($urandom));
            13:     send_word(ACT_WR_KEY, 10'($urandom), rand_key(), rand_key(), 11'($urandom));
            14:     send_word(ACT_NONE, 10'($urandom), rand_key(), rand_key(), 11'($urandom));
            default: send_word(ACT_LOOKUP, 10'($urandom), '1, '1, 11'($urandom));
        endcase
    endtask

    initial begin
        int         total;
        bit [10:0]  tsz_set [7];
        bit [10:0]  osz_set [7];
        in_ch.valid = 1'b0;
        in_ch.action = ACT_NONE;
        in_ch.slot_index = '0;
        in_ch.key_high = '0;
        in_ch.key_low = '0;
        in_ch.offset_value = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_TABLE_SIZE;
        cfg_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // load every displacement entry so no lookup reads an unwritten one
        for (int i = 0; i < OFFSET_DEPTH; i++) begin
            send_word(ACT_WR_OFFSET, 10'(i), '0, '0,
                      (i == 0) ? 11'd0 : (i == 1) ? 11'h7FF : 11'($urandom));
        end

        // directed: extremes, every action, the special cases
        send_word(ACT_WR_OFFSET, 10'd255, '0, '0, 11'd5);
        send_word(ACT_LOOKUP, 10'd0, '1, '1, 11'd0);            // carry out of 128 bits
        send_word(ACT_WR_OFFSET, 10'd256, '0, '0, 11'h7FF);     // displacement index past size
        send_word(ACT_WR_OFFSET, 10'h3FF, '0, '0, 11'h7FF);
        send_word(ACT_WR_KEY, 10'h3FF, '1, '1, 11'd0);
        send_word(ACT_LOOKUP, 10'h3FF, '0, '0, 11'd0);          // zero key never hits
        send_word(ACT_NONE, 10'h3FF, '1, '1, 11'h7FF);          // unused action
        store_and_find('1, 64'hFFFF_FFFF_FFFF_FF00);
        store_and_find(64'd0, 64'd1);
        store_and_find(64'h8000_0000_0000_0000, 64'd0);
        send_word(ACT_WR_KEY, 10'd0, '0, '0, 11'd0);            // zero key empties a slot
        send_word(ACT_LOOKUP, 10'd0, 64'd0, 64'd0, 11'd0);

        // settings, extremes among them; sizes above depth and zero sizes included
        tsz_set = '{11'd1024, 11'd1, 11'd0, 11'h7FF, 11'd1000, 11'd37, 11'd3};
        osz_set = '{11'd256, 11'd1, 11'd0, 11'h7FF, 11'd200, 11'd255, 11'd2};
        total = 0;
        for (int ph = 0; ph < 8; ph++) begin
            if (ph < 7) reconfigure(tsz_set[ph], osz_set[ph], 1'b1);
            else reconfigure(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 256)), 1'b0);
            for (int n = 0; n < 85; n++) begin
                if (ph == 7 && n >= 42) calm = 1'b1;
                random_word();
                total++;
            end
        end

        in_ch.valid <= 1'b0;
        while (sb.answers.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        $display("covered %0d results: %0d hits, %0d overflows, eight register settings",
                 sb.checked, sb.hits, sb.overflows);
        $display("random part drove %0d store/lookup actions", total);
        if (sb.errors == 0 && sb.answers.size() == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
